FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rfae_pkg.sv
// ----------------------------------------------------------------------------
// rfae_pkg
// types, constants and microcode program of the rotor flux angle estimator
// ----------------------------------------------------------------------------
package rfae_pkg;

	// field widths
	localparam int CUR_W   = 16;
	localparam int SPD_W   = 24;
	localparam int ANG_W   = 16;
	localparam int K_W     = 16;
	localparam int THR_W   = 15;
	localparam int GAIN_W  = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_AW  = 2;

	// divider: dividend is |K * iq| / 16, divisor is |id|
	localparam int NUM_W   = CUR_W + K_W - 1;
	localparam int DIV_BITS = NUM_W - 4;
	localparam int DCNT_W  = $clog2(DIV_BITS);
	localparam int PROD_W  = SPD_W + GAIN_W;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_INV_TR   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ID_MIN   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_SLIP_GAIN = 2'd2;

	// reset values
	localparam logic [K_W-1:0]    INV_TR_RST   = 16'd256;
	localparam logic [THR_W-1:0]  ID_MIN_RST   = 15'd64;
	localparam logic [GAIN_W-1:0] SLIP_GAIN_RST = 24'd1024;

	// saturation limits
	localparam logic [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
	localparam logic [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

	// program addresses
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
	localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
	localparam logic [PC_W-1:0] PC_DINIT = 3'd2;
	localparam logic [PC_W-1:0] PC_DSTEP = 3'd3;
	localparam logic [PC_W-1:0] PC_SLIP  = 3'd4;
	localparam logic [PC_W-1:0] PC_SPEED = 3'd5;
	localparam logic [PC_W-1:0] PC_ANGLE = 3'd6;
	localparam logic [PC_W-1:0] PC_OUT   = 3'd7;

	// jump conditions
	typedef logic [2:0] jump_t;
	localparam jump_t JC_NEXT     = 3'd0;
	localparam jump_t JC_NO_INPUT = 3'd1;
	localparam jump_t JC_SMALL_ID = 3'd2;
	localparam jump_t JC_DIV_BUSY = 3'd3;
	localparam jump_t JC_OUT_BUSY = 3'd4;

	// one control word
	typedef struct packed {
		logic            accept;
		logic            mul_num;
		logic            div_init;
		logic            div_step;
		logic            slip_upd;
		logic            speed_mul;
		logic            angle_upd;
		logic            out_load;
		jump_t           cond;
		logic [PC_W-1:0] target;
	} uop_t;

	localparam uop_t UOP_NOP = '{default: '0};

	// program rom
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = UOP_NOP;
		unique case (pc)
			PC_WAIT: begin
				u.accept = 1'b1;
				u.cond   = JC_NO_INPUT;
				u.target = PC_WAIT;
			end
			PC_CHECK: begin
				u.mul_num = 1'b1;
				u.cond    = JC_SMALL_ID;
				u.target  = PC_SPEED;
			end
			PC_DINIT: u.div_init = 1'b1;
			PC_DSTEP: begin
				u.div_step = 1'b1;
				u.cond     = JC_DIV_BUSY;
				u.target   = PC_DSTEP;
			end
			PC_SLIP:  u.slip_upd = 1'b1;
			PC_SPEED: u.speed_mul = 1'b1;
			PC_ANGLE: u.angle_upd = 1'b1;
			PC_OUT: begin
				u.out_load = 1'b1;
				u.cond     = JC_OUT_BUSY;
				u.target   = PC_OUT;
			end
			default: u = UOP_NOP;
		endcase
		return u;
	endfunction

endpackage

FILE: rtl/rotor_flux_angle_estimator_core.sv
// ----------------------------------------------------------------------------
// rotor_flux_angle_estimator_core
// slip speed, flux speed and flux angle from current references and rotor data
// ----------------------------------------------------------------------------
// One input beat gives one output beat; the next beat is accepted only in
// the wait step. A small microcoded program steps a plain datapath: with
// |id| above the threshold the restoring divider for iq/id takes one quotient
// bit per cycle for its 27 quotient bits; with |id| at or below the threshold
// the held slip speed is reused and the divider is skipped. The result sits in
// an output register; a stalled output holds the sequencer in its last step.
module rotor_flux_angle_estimator_core
	import rfae_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic [CFG_AW-1:0]        cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CUR_W-1:0]  iq_ref,
	input  logic signed [CUR_W-1:0]  id_ref,
	input  logic signed [SPD_W-1:0]  rotor_speed,
	input  logic [ANG_W-1:0]         rotor_angle,
	// output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SPD_W-1:0]  slip_speed,
	output logic signed [SPD_W-1:0]  flux_speed,
	output logic [ANG_W-1:0]         flux_angle
);

	// configuration registers
	logic [K_W-1:0]    inv_tr_q;
	logic [THR_W-1:0]  id_min_q;
	logic [GAIN_W-1:0] gain_q;

	// sequencer
	logic [PC_W-1:0] pc_q;
	uop_t            uop;
	logic            take_jump;
	logic            out_free;

	// captured item
	logic signed [CUR_W-1:0] iq_q;
	logic signed [CUR_W-1:0] id_q;
	logic signed [SPD_W-1:0] wr_q;
	logic [ANG_W-1:0]        ang_q;

	// datapath
	logic [CUR_W-1:0]   abs_iq;
	logic [CUR_W-1:0]   abs_id;
	logic               small_id;
	logic [NUM_W-1:0]   num_q;
	logic               qneg_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [CUR_W-1:0]   rem_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [CUR_W:0]     trial;
	logic [CUR_W:0]     trial_diff;
	logic signed [SPD_W-1:0] slip_sat;
	logic signed [SPD_W-1:0] held_q;
	logic signed [SPD_W:0]   speed_sum;
	logic signed [SPD_W-1:0] flux_speed_q;
	logic [SPD_W-1:0]   held_mag;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  prod_rnd;
	logic [ANG_W-1:0]   slip_ang;
	logic [ANG_W-1:0]   acc_q;
	logic [ANG_W-1:0]   last_ang_q;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tr_q <= INV_TR_RST;
			id_min_q <= ID_MIN_RST;
			gain_q   <= SLIP_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_TR:    inv_tr_q <= cfg_data[K_W-1:0];
				REG_ID_MIN:    id_min_q <= cfg_data[THR_W-1:0];
				REG_SLIP_GAIN: gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// control word and branch decision
	assign uop      = ucode(pc_q);
	assign out_free = !out_valid || out_ready;
	assign in_ready = uop.accept;

	always_comb begin
		unique case (uop.cond)
			JC_NO_INPUT: take_jump = !in_valid;
			JC_SMALL_ID: take_jump = small_id;
			JC_DIV_BUSY: take_jump = (div_cnt_q != DCNT_W'(DIV_BITS - 1));
			JC_OUT_BUSY: take_jump = !out_free;
			default:     take_jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take_jump) begin
			pc_q <= uop.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

	// capture input beat
	always_ff @(posedge clk) begin
		if (uop.accept && in_valid) begin
			iq_q  <= iq_ref;
			id_q  <= id_ref;
			wr_q  <= rotor_speed;
			ang_q <= rotor_angle;
		end
	end

	// magnitudes and threshold test
	assign abs_iq   = iq_q[CUR_W-1] ? CUR_W'(-iq_q) : CUR_W'(iq_q);
	assign abs_id   = id_q[CUR_W-1] ? CUR_W'(-id_q) : CUR_W'(id_q);
	assign small_id = (abs_id <= {1'b0, id_min_q});

	// numerator magnitude |K * iq|
	always_ff @(posedge clk) begin
		if (uop.mul_num) begin
			num_q  <= NUM_W'(abs_iq) * NUM_W'(inv_tr_q);
			qneg_q <= iq_q[CUR_W-1] ^ id_q[CUR_W-1];
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial      = {rem_q, dvd_q[DIV_BITS-1]};
	assign trial_diff = trial - {1'b0, abs_id};

	always_ff @(posedge clk) begin
		if (uop.div_init) begin
			dvd_q     <= num_q[NUM_W-1:4];
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (uop.div_step) begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
			if (!trial_diff[CUR_W]) begin
				rem_q <= trial_diff[CUR_W-1:0];
				dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[CUR_W-1:0];
				dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	// signed quotient saturated to the speed range
	always_comb begin
		if (qneg_q) begin
			if (dvd_q > DIV_BITS'(SPD_MIN)) slip_sat = SPD_MIN;
			else                             slip_sat = SPD_W'(-dvd_q);
		end else begin
			if (dvd_q > DIV_BITS'(SPD_MAX)) slip_sat = SPD_MAX;
			else                             slip_sat = SPD_W'(dvd_q);
		end
	end

	// flux speed and slip angle product
	assign speed_sum = {wr_q[SPD_W-1], wr_q} + {held_q[SPD_W-1], held_q};
	assign held_mag  = held_q[SPD_W-1] ? SPD_W'(-held_q) : SPD_W'(held_q);

	always_ff @(posedge clk) begin
		if (uop.speed_mul) begin
			prod_q <= PROD_W'(held_mag) * PROD_W'(gain_q);
			if (speed_sum[SPD_W] != speed_sum[SPD_W-1]) begin
				flux_speed_q <= speed_sum[SPD_W] ? SPD_MIN : SPD_MAX;
			end else begin
				flux_speed_q <= speed_sum[SPD_W-1:0];
			end
		end
	end

	// rounded slip angle, sign applied modulo one turn
	assign prod_rnd = prod_q + (PROD_W'(1) << (GAIN_W - 1));
	assign slip_ang = held_q[SPD_W-1] ? ANG_W'(-prod_rnd[GAIN_W +: ANG_W])
	                                  : prod_rnd[GAIN_W +: ANG_W];

	// persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			acc_q      <= '0;
			last_ang_q <= '0;
		end else begin
			if (uop.slip_upd) begin
				held_q <= slip_sat;
			end
			if (uop.angle_upd) begin
				acc_q      <= acc_q - slip_ang + ang_q - last_ang_q;
				last_ang_q <= ang_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (uop.out_load && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uop.out_load && out_free) begin
			slip_speed <= held_q;
			flux_speed <= flux_speed_q;
			flux_angle <= acc_q;
		end
	end

	// checks
	`include "assert_macros.svh"

	`ASSERT_IMPL(a_out_from_prog, $rose(out_valid), $past(pc_q) == PC_OUT, "stray result")
	`ASSERT_NEXT(a_one_accept, in_valid && in_ready, !in_ready, "second beat accepted while busy")
	`ASSERT_NEXT(a_hold_small_id, pc_q == PC_CHECK && small_id, $stable(held_q), "slip moved")
	`ASSERT_IMPL(a_div_count, pc_q == PC_DSTEP, div_cnt_q < DCNT_W'(DIV_BITS), "divider overrun")
	`ASSERT_ALWAYS(a_ready_idle, in_ready == (pc_q == PC_WAIT), "ready outside wait step")

endmodule
